// ===== src/ovl_pkg.sv =====
// Shared types and constants for the RGB565 alpha rectangle overlay.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ovl_pkg;

  localparam int MAX_FRAME_WIDTH_DEF  = 2048;
  localparam int MAX_FRAME_HEIGHT_DEF = 2048;

  localparam int REG_W     = 12;
  localparam int RGBA_W    = 32;
  localparam int DIM_W     = 13;   // holds a frame size up to 8191
  localparam int SPAN_W    = 15;   // signed rectangle edge arithmetic
  localparam int PIX_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_RGBA    = 3'd6;

  localparam logic [REG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [REG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // queue between front and back; depth must be a power of two
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [REG_W-1:0]  frame_width;
    logic [REG_W-1:0]  frame_height;
    logic [REG_W-1:0]  rect_left;
    logic [REG_W-1:0]  rect_top;
    logic [REG_W-1:0]  rect_width;
    logic [REG_W-1:0]  rect_height;
    logic [RGBA_W-1:0] fill_rgba;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             cov;
  } item_t;

  typedef struct packed {
    logic            full;
    logic            empty;
    logic [Q_CW-1:0] count;
  } q_stat_t;

endpackage

// ===== src/ovl_front.sv =====
// Front end: raster position counters and rectangle hit test.
// Depends on ovl_pkg; feeds classified words into ovl_fifo.
`timescale 1ns / 1ps

module ovl_front #(
  parameter int MAX_FRAME_WIDTH  = ovl_pkg::MAX_FRAME_WIDTH_DEF,
  parameter int MAX_FRAME_HEIGHT = ovl_pkg::MAX_FRAME_HEIGHT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ovl_pkg::cfg_t            cfg,
  input  logic                     in_valid,
  input  logic [ovl_pkg::PIX_W-1:0] in_pix,
  input  logic                     in_frame_start,
  output logic                     in_ready,
  input  ovl_pkg::q_stat_t         q_stat,
  output logic                     push,
  output ovl_pkg::item_t           push_item
);

  localparam int CW = $clog2(MAX_FRAME_WIDTH);
  localparam int RW = $clog2(MAX_FRAME_HEIGHT);

  logic [CW-1:0] col_r, col_nxt, col_cur;
  logic [RW-1:0] row_r, row_nxt, row_cur;
  logic [ovl_pkg::DIM_W-1:0] fw_eff, fh_eff, col_inc, row_inc;
  logic signed [ovl_pkg::SPAN_W-1:0] x_pos, y_pos, x_lo, y_lo, x_hi, y_hi;
  logic in_x, in_y;

  always_comb begin
    fw_eff = (ovl_pkg::DIM_W'(cfg.frame_width) > ovl_pkg::DIM_W'(MAX_FRAME_WIDTH)) ?
             ovl_pkg::DIM_W'(MAX_FRAME_WIDTH) : ovl_pkg::DIM_W'(cfg.frame_width);
    fh_eff = (ovl_pkg::DIM_W'(cfg.frame_height) > ovl_pkg::DIM_W'(MAX_FRAME_HEIGHT)) ?
             ovl_pkg::DIM_W'(MAX_FRAME_HEIGHT) : ovl_pkg::DIM_W'(cfg.frame_height);

    col_cur = in_frame_start ? '0 : col_r;
    row_cur = in_frame_start ? '0 : row_r;

    x_pos = $signed(ovl_pkg::SPAN_W'(col_cur));
    y_pos = $signed(ovl_pkg::SPAN_W'(row_cur));
    x_lo  = ovl_pkg::SPAN_W'($signed(cfg.rect_left));
    y_lo  = ovl_pkg::SPAN_W'($signed(cfg.rect_top));
    x_hi  = x_lo + $signed(ovl_pkg::SPAN_W'(cfg.rect_width));
    y_hi  = y_lo + $signed(ovl_pkg::SPAN_W'(cfg.rect_height));

    in_x = (ovl_pkg::DIM_W'(col_cur) < fw_eff) && (x_pos >= x_lo) && (x_pos < x_hi);
    in_y = (ovl_pkg::DIM_W'(row_cur) < fh_eff) && (y_pos >= y_lo) && (y_pos < y_hi);

    col_inc = ovl_pkg::DIM_W'(col_cur) + 1'b1;
    row_inc = ovl_pkg::DIM_W'(row_cur) + 1'b1;
    row_nxt = row_cur;
    if (col_inc >= fw_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= fh_eff) ? '0 : row_inc[RW-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
    end
  end

  assign in_ready      = !q_stat.full;
  assign push          = in_valid && in_ready;
  assign push_item.pix = in_pix;
  assign push_item.cov = (cfg.fill_rgba[7:0] != 8'd0) && in_x && in_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== src/ovl_fifo.sv =====
// Short word queue decoupling the front end from the blend pipeline.
// Depends on ovl_pkg for the word type and depth.
`timescale 1ns / 1ps

module ovl_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ovl_pkg::item_t   push_item,
  input  logic             pop,
  output ovl_pkg::item_t   pop_item,
  output ovl_pkg::q_stat_t stat
);

  ovl_pkg::item_t             mem_r [ovl_pkg::Q_DEPTH];
  logic [ovl_pkg::Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [ovl_pkg::Q_CW-1:0]   cnt_r;

  assign pop_item   = mem_r[rd_ptr_r];
  assign stat.count = cnt_r;
  assign stat.full  = (cnt_r == ovl_pkg::Q_CW'(ovl_pkg::Q_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== src/ovl_back.sv =====
// Back end: two-stage alpha blend pipeline with registered output.
// Depends on ovl_pkg; drains words from ovl_fifo.
`timescale 1ns / 1ps

module ovl_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ovl_pkg::cfg_t             cfg,
  input  ovl_pkg::q_stat_t          q_stat,
  input  ovl_pkg::item_t            q_item,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ovl_pkg::PIX_W-1:0] out_pix,
  output logic                      out_cov
);

  // x / 255, exact for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  logic [7:0] a, inv_a, fr, fg, fb, dr, dg, db, qr, qg, qb;
  logic [15:0] sr, sg, sb;
  logic        s1_en, out_en;

  logic                      s1_valid_r;
  logic [ovl_pkg::PIX_W-1:0] s1_pix_r;
  logic                      s1_cov_r;
  logic [15:0]               s1_r_r, s1_g_r, s1_b_r;

  logic                      out_valid_r;
  logic [ovl_pkg::PIX_W-1:0] out_pix_r;
  logic                      out_cov_r;

  always_comb begin
    a     = cfg.fill_rgba[7:0];
    inv_a = 8'hFF - a;
    fr    = cfg.fill_rgba[31:24];
    fg    = cfg.fill_rgba[23:16];
    fb    = cfg.fill_rgba[15:8];
    dr    = {q_item.pix[15:11], 3'b000};
    dg    = {q_item.pix[10:5], 2'b00};
    db    = {q_item.pix[4:0], 3'b000};
    // alpha 255 gives c*255/255 = c, so no separate replace path
    sr    = 16'(fr) * 16'(a) + 16'(dr) * 16'(inv_a);
    sg    = 16'(fg) * 16'(a) + 16'(dg) * 16'(inv_a);
    sb    = 16'(fb) * 16'(a) + 16'(db) * 16'(inv_a);
    qr    = div255(s1_r_r);
    qg    = div255(s1_g_r);
    qb    = div255(s1_b_r);
  end

  assign out_en = !out_valid_r || out_ready;
  assign s1_en  = !s1_valid_r || out_en;
  assign pop    = !q_stat.empty && s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_en)  s1_valid_r  <= !q_stat.empty;
      if (out_en) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_pix_r <= q_item.pix;
      s1_cov_r <= q_item.cov;
      s1_r_r   <= sr;
      s1_g_r   <= sg;
      s1_b_r   <= sb;
    end
    if (out_en) begin
      out_cov_r <= s1_cov_r;
      out_pix_r <= s1_cov_r ? {qr[7:3], qg[7:2], qb[7:3]} : s1_pix_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;
  assign out_cov   = out_cov_r;

endmodule

// ===== src/rgb565_alpha_rect_overlay.sv =====
// A word passes queue, blend and output registers; one word per cycle unless stalled.
// Throughput is set by the blend pipeline, which advances one word per clock when not stalled.
// A four-word queue between hit test and blend absorbs output back-pressure.
// Synchronous active-low reset: position counters zero, queue and pipeline empty,
// registers to 640 x 480 frame, empty rectangle, fill colour zero.
`timescale 1ns / 1ps

module rgb565_alpha_rect_overlay #(
  parameter int MAX_FRAME_WIDTH  = ovl_pkg::MAX_FRAME_WIDTH_DEF,
  parameter int MAX_FRAME_HEIGHT = ovl_pkg::MAX_FRAME_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // pixel_in
  input  logic                          in_tuser,   // frame_start
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // pixel_out
  output logic                          out_tuser,  // covered
  input  logic                          cfg_we,
  input  logic [ovl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ovl_pkg::RGBA_W-1:0]    cfg_wdata
);

  ovl_pkg::cfg_t    cfg_r;
  ovl_pkg::q_stat_t q_stat;
  ovl_pkg::item_t   push_item, pop_item;
  logic             q_push, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= ovl_pkg::FRAME_WIDTH_RST;
      cfg_r.frame_height <= ovl_pkg::FRAME_HEIGHT_RST;
      cfg_r.rect_left    <= '0;
      cfg_r.rect_top     <= '0;
      cfg_r.rect_width   <= '0;
      cfg_r.rect_height  <= '0;
      cfg_r.fill_rgba    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ovl_pkg::REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_wdata[ovl_pkg::REG_W-1:0];
        ovl_pkg::REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_wdata[ovl_pkg::REG_W-1:0];
        ovl_pkg::REG_RECT_LEFT:    cfg_r.rect_left    <= cfg_wdata[ovl_pkg::REG_W-1:0];
        ovl_pkg::REG_RECT_TOP:     cfg_r.rect_top     <= cfg_wdata[ovl_pkg::REG_W-1:0];
        ovl_pkg::REG_RECT_WIDTH:   cfg_r.rect_width   <= cfg_wdata[ovl_pkg::REG_W-1:0];
        ovl_pkg::REG_RECT_HEIGHT:  cfg_r.rect_height  <= cfg_wdata[ovl_pkg::REG_W-1:0];
        ovl_pkg::REG_FILL_RGBA:    cfg_r.fill_rgba    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ovl_front #(
    .MAX_FRAME_WIDTH  (MAX_FRAME_WIDTH),
    .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_tvalid),
    .in_pix         (in_tdata),
    .in_frame_start (in_tuser),
    .in_ready       (in_tready),
    .q_stat         (q_stat),
    .push           (q_push),
    .push_item      (push_item)
  );

  ovl_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  ovl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .q_item    (pop_item),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (out_tdata),
    .out_cov   (out_tuser)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.count != '0)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= ovl_pkg::Q_CW'(ovl_pkg::Q_DEPTH))
    else $error("queue count beyond depth");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && q_stat.empty)
    else $error("pipeline not empty after reset");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for rgb565_alpha_rect_overlay: directed corner frames, then random frames.
// Depends on ovl_pkg and the block RTL; a scoreboard class predicts every output word.
`timescale 1ns / 1ps

module testbench;
  import ovl_pkg::*;

  localparam int NUM_REGS        = REG_FILL_RGBA + 1;
  localparam int RANDOM_WORDS    = 500;
  localparam int WATCHDOG_CYCLES = 2000;

  class overlay_scoreboard;
    cfg_t        regs;
    int unsigned col_pos;
    int unsigned row_pos;
    item_t       expected_pixels[$];
    int          errors;

    function new();
      regs              = '0;
      regs.frame_width  = FRAME_WIDTH_RST;
      regs.frame_height = FRAME_HEIGHT_RST;
      col_pos           = 0;
      row_pos           = 0;
      errors            = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [RGBA_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH:  regs.frame_width  = data[REG_W-1:0];
        REG_FRAME_HEIGHT: regs.frame_height = data[REG_W-1:0];
        REG_RECT_LEFT:    regs.rect_left    = data[REG_W-1:0];
        REG_RECT_TOP:     regs.rect_top     = data[REG_W-1:0];
        REG_RECT_WIDTH:   regs.rect_width   = data[REG_W-1:0];
        REG_RECT_HEIGHT:  regs.rect_height  = data[REG_W-1:0];
        REG_FILL_RGBA:    regs.fill_rgba    = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    static function bit in_span(int pos, int start, int len, int size);
      return pos < size && pos >= start && pos < start + len;
    endfunction

    static function logic [7:0] mix(int fill, int old, int alpha);
      return 8'((fill * alpha + old * (255 - alpha)) / 255);
    endfunction

    // one accepted input word -> one expected output word, then step the raster position
    function void predict_pixel(logic [PIX_W-1:0] pix, logic frame_start);
      int         fw;
      int         fh;
      logic [7:0] alpha;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      item_t      want;
      fw = regs.frame_width > MAX_FRAME_WIDTH_DEF ? MAX_FRAME_WIDTH_DEF : int'(regs.frame_width);
      fh = regs.frame_height > MAX_FRAME_HEIGHT_DEF ? MAX_FRAME_HEIGHT_DEF
                                                    : int'(regs.frame_height);
      if (frame_start) begin
        col_pos = 0;
        row_pos = 0;
      end
      alpha    = regs.fill_rgba[7:0];
      want.pix = pix;
      want.cov = alpha != 8'h00
        && in_span(col_pos, int'($signed(regs.rect_left)), int'(regs.rect_width), fw)
        && in_span(row_pos, int'($signed(regs.rect_top)), int'(regs.rect_height), fh);
      if (want.cov) begin
        r = regs.fill_rgba[31:24];
        g = regs.fill_rgba[23:16];
        b = regs.fill_rgba[15:8];
        if (alpha != 8'hFF) begin
          r = mix(r, {pix[15:11], 3'b000}, alpha);
          g = mix(g, {pix[10:5], 2'b00}, alpha);
          b = mix(b, {pix[4:0], 3'b000}, alpha);
        end
        want.pix = {r[7:3], g[7:2], b[7:3]};
      end
      expected_pixels.push_back(want);
      if (col_pos + 1 >= fw) begin
        col_pos = 0;
        if (row_pos + 1 >= fh) row_pos = 0;
        else row_pos++;
      end else begin
        col_pos++;
      end
    endfunction

    function void check_pixel(logic [PIX_W-1:0] pix, logic cov);
      item_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected output word: pixel_out %h covered %b", pix, cov);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (pix !== want.pix) begin
        $error("pixel_out: expected %h, got %h", want.pix, pix);
        errors++;
      end
      if (cov !== want.cov) begin
        $error("covered: expected %b, got %b", want.cov, cov);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [15:0]          in_tdata;   // pixel_in
  logic                 in_tuser;   // frame_start
  logic                 out_tvalid;
  logic                 out_tready;
  logic [15:0]          out_tdata;  // pixel_out
  logic                 out_tuser;  // covered
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RGBA_W-1:0]    cfg_wdata;

  overlay_scoreboard board;
  int gap_odds   = 3;
  int stall_odds = 3;
  int idle_cycles;
  int stall_left;

  rgb565_alpha_rect_overlay dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // odds 0: never pause; otherwise 1 in odds, mostly short, now and then long
  function automatic int pick_pause(int odds);
    if (odds == 0 || $urandom_range(odds - 1, 0) != 0) return 0;
    if ($urandom_range(9, 0) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(2, 0))
      0: return 0;
      1: return 2;
      default: return 6;
    endcase
  endfunction

  function automatic int pick_dim(int most);
    case ($urandom_range(15, 0))
      0: return 0;
      1: return MAX_FRAME_WIDTH_DEF;
      2: return $urandom_range(4095, MAX_FRAME_WIDTH_DEF + 1);
      default: return $urandom_range(most, 1);
    endcase
  endfunction

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(9, 0))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cfg_t make_setup(int fw, int fh, int left, int top, int w, int h,
                                      logic [31:0] rgba);
    cfg_t c;
    c.frame_width  = 12'(fw);
    c.frame_height = 12'(fh);
    c.rect_left    = 12'(left);
    c.rect_top     = 12'(top);
    c.rect_width   = 12'(w);
    c.rect_height  = 12'(h);
    c.fill_rgba    = rgba;
    return c;
  endfunction

  function automatic cfg_t random_setup();
    cfg_t c;
    int   span_w;
    int   span_h;
    c.frame_width  = 12'(pick_dim(12));
    c.frame_height = 12'(pick_dim(8));
    span_w = c.frame_width > 16 ? 16 : int'(c.frame_width);
    span_h = c.frame_height > 16 ? 16 : int'(c.frame_height);
    if ($urandom_range(7, 0) == 0) begin
      c.rect_left  = 12'($urandom);
      c.rect_width = 12'($urandom);
    end else begin
      c.rect_left  = 12'($urandom_range(span_w + 2, 0) - 3);
      c.rect_width = 12'($urandom_range(span_w + 4, 0));
    end
    if ($urandom_range(7, 0) == 0) begin
      c.rect_top    = 12'($urandom);
      c.rect_height = 12'($urandom);
    end else begin
      c.rect_top    = 12'($urandom_range(span_h + 2, 0) - 3);
      c.rect_height = 12'($urandom_range(span_h + 4, 0));
    end
    c.fill_rgba[31:8] = 24'($urandom);
    case ($urandom_range(7, 0))
      0: c.fill_rgba[7:0] = 8'h00;
      1: c.fill_rgba[7:0] = 8'hFF;
      2: c.fill_rgba[7:0] = 8'h01;
      3: c.fill_rgba[7:0] = 8'hFE;
      default: c.fill_rgba[7:0] = 8'($urandom);
    endcase
    return c;
  endfunction

  task automatic send_pixel(input logic [15:0] pix, input logic fs);
    int pause;
    pause = pick_pause(gap_odds);
    if (pause > 0) begin
      in_tvalid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= fs;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // hold the sender until every outstanding word has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_regs(input cfg_t c);
    logic [RGBA_W-1:0] value [NUM_REGS];
    value[REG_FRAME_WIDTH]  = 32'(c.frame_width);
    value[REG_FRAME_HEIGHT] = 32'(c.frame_height);
    value[REG_RECT_LEFT]    = 32'(c.rect_left);
    value[REG_RECT_TOP]     = 32'(c.rect_top);
    value[REG_RECT_WIDTH]   = 32'(c.rect_width);
    value[REG_RECT_HEIGHT]  = 32'(c.rect_height);
    value[REG_FILL_RGBA]    = c.fill_rgba;
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= value[i];
      @(posedge clk);
      board.write_reg(CFG_IDX_W'(i), value[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.predict_pixel(in_tdata, in_tuser);
    if (rst_n && out_tvalid && out_tready) board.check_pixel(out_tdata, out_tuser);
  end

  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        stall_left = pick_pause(stall_odds);
        out_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    cfg_t setup;
    int   sent;
    int   burst;
    int   frame_len;
    logic fs;
    board     = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset registers: empty rectangle, nothing covered
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hFFFF, 1'b0);

    // opaque fill, rectangle hanging off the top-left corner
    settle();
    program_regs(make_setup(4, 3, -2, -1, 4, 3, 32'hFF00FFFF));
    for (int k = 0; k < 12; k++) send_pixel(k[0] ? 16'hFFFF : 16'h0000, k == 0);

    // alpha zero passes everything
    settle();
    program_regs(make_setup(4, 3, 0, 0, 4, 3, 32'h12345600));
    for (int k = 0; k < 3; k++) send_pixel(pick_pixel(), k == 0);

    // zero frame width: nothing lies inside the frame
    settle();
    program_regs(make_setup(0, 3, -2048, -2048, 4095, 4095, 32'hFFFFFFFF));
    send_pixel(16'h1234, 1'b1);
    send_pixel(16'hFFFF, 1'b0);

    // weakest and strongest partial blends
    settle();
    program_regs(make_setup(2, 2, 0, 0, 2, 2, 32'hFFFFFF01));
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hFFFF, 1'b0);
    settle();
    program_regs(make_setup(2, 2, 0, 0, 2, 2, 32'h000000FE));
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h8410, 1'b0);

    // frame size beyond the maximum, rectangle at the field extremes
    settle();
    program_regs(make_setup(4095, 4095, -2048, -2048, 4095, 4095, 32'hA5C3F080));
    send_pixel(16'hF81F, 1'b1);
    send_pixel(16'h07E0, 1'b0);

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      setup      = random_setup();
      gap_odds   = pick_odds();
      stall_odds = pick_odds();
      settle();
      program_regs(setup);
      frame_len = (setup.frame_width > MAX_FRAME_WIDTH_DEF ? MAX_FRAME_WIDTH_DEF
                                                           : int'(setup.frame_width))
                * (setup.frame_height > MAX_FRAME_HEIGHT_DEF ? MAX_FRAME_HEIGHT_DEF
                                                             : int'(setup.frame_height));
      burst = $urandom_range(60, 20);
      for (int k = 0; k < burst; k++) begin
        fs = frame_len != 0 ? (k % frame_len == 0) : (k == 0);
        if ($urandom_range(24, 0) == 0) fs = ~fs;   // broken frames
        if ($urandom_range(59, 0) == 0) settle();
        send_pixel(pick_pixel(), fs);
      end
      sent += burst;
    end

    settle();
    repeat (8) @(negedge clk);
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
